>>> rtl/far_pkg.sv
`default_nettype none

package far_pkg;

  localparam int unsigned ADDR_W   = 64;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_END   = 2'd1;

  typedef enum logic [STATUS_W-1:0] {
    STAT_GRANTED       = 2'd0,
    STAT_NO_RANGE      = 2'd1,
    STAT_NOT_CONTAINED = 2'd2,
    STAT_FULL          = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    UPD_NONE,
    UPD_LOAD,
    UPD_DROP,
    UPD_TRIM_FRONT,
    UPD_TRIM_BACK,
    UPD_SPLIT
  } upd_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } state_t;

  // Search word handed from cell to cell
  typedef struct packed {
    logic              go;
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic [ADDR_W-1:0] best_base;
    logic [ADDR_W-1:0] best_limit;
    logic              spare_found;
  } scan_t;

  // Table update broadcast to every cell
  typedef struct packed {
    upd_op_t           op;
    logic [ADDR_W-1:0] val_base;
    logic [ADDR_W-1:0] val_limit;
    logic [ADDR_W-1:0] val_split_limit;
  } upd_t;

endpackage

`default_nettype wire

>>> rtl/fixed_address_range_allocator.sv
// Fixed-address range allocator. Holds a table of FREE_ENTRIES free address
// ranges [base, limit), one per cell of a chain; after reset, and after any
// write of pool_start (index 0) or pool_end (index 1), the table holds the
// single range [pool_start, pool_end). A request word asks for the span
// [addr, addr + size); the block picks the free range with the greatest
// start at or below addr (lowest slot on a tie), checks that it holds the
// span, and then drops, trims or splits it, a split taking the lowest free
// slot. The result word carries status (0 granted, 1 no range below, 2 not
// contained or end overflow, 3 table full) and the granted span, zero on
// error. One request is handled at a time: a search word walks the cell
// chain one cell per cycle, a register latches the search result, and the
// DECIDE state decides and commits the table update; the commit waits while
// an earlier result word still sits unread in the output register. The next
// request can be taken in the same cycle that the result appears, even while
// that result waits.
// Write configuration only while idle; writes to other indexes are dropped.
`default_nettype none

module fixed_address_range_allocator
  import far_pkg::*;
#(
  parameter int unsigned FREE_ENTRIES = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // request channel
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [ADDR_W-1:0]    in_request_addr,
  input  wire logic [ADDR_W-1:0]    in_request_size,
  // result channel
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic [STATUS_W-1:0]  out_status,
  output      logic [ADDR_W-1:0]    out_granted_start,
  output      logic [ADDR_W-1:0]    out_granted_end,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data
);

  localparam int unsigned IDX_W = $clog2(FREE_ENTRIES);

  // Control state
  state_t state_r, state_nxt;
  logic   launch_r, launch_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Pool registers
  logic [ADDR_W-1:0] pool_start_r, pool_end_r;

  // Request and search result, held while the item is in flight
  logic [ADDR_W-1:0] addr_r, req_end_r;
  logic              ovf_r;
  logic [ADDR_W:0]   sum;
  scan_t             res_r;
  logic [IDX_W-1:0]  res_best_idx_r, res_spare_idx_r;

  // Output payload
  status_t           out_status_r;
  logic [ADDR_W-1:0] out_start_r, out_end_r;

  // Chain links
  scan_t            link     [FREE_ENTRIES+1];
  logic [IDX_W-1:0] best_idx [FREE_ENTRIES+1];
  logic [IDX_W-1:0] spare_idx[FREE_ENTRIES+1];

  // Decision and update broadcast
  status_t dec_status;
  upd_op_t dec_op;
  upd_t    upd;
  logic    in_fire, cfg_fire, cfg_load, commit;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_load  = cfg_fire &&
                     ((cfg_index == CFG_POOL_START) || (cfg_index == CFG_POOL_END));
  assign commit    = (state_r == ST_DECIDE) && (!out_valid_r || out_ready);
  assign sum       = {1'b0, in_request_addr} + {1'b0, in_request_size};

  // Feed the head of the chain; the search word is live for one cycle.
  always_comb begin
    link[0]             = '0;
    link[0].go          = launch_r;
    link[0].addr        = addr_r;
    best_idx[0]         = '0;
    spare_idx[0]        = '0;
  end

  for (genvar i = 0; i < FREE_ENTRIES; i++) begin : g_cell
    far_cell #(
      .ENTRIES (FREE_ENTRIES),
      .SLOT    (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .scan_i      (link[i]),
      .best_idx_i  (best_idx[i]),
      .spare_idx_i (spare_idx[i]),
      .scan_o      (link[i+1]),
      .best_idx_o  (best_idx[i+1]),
      .spare_idx_o (spare_idx[i+1]),
      .upd_i       (upd),
      .sel_idx_i   (res_best_idx_r),
      .spr_idx_i   (res_spare_idx_r)
    );
  end

  // Classify the request against the chosen range. The search already
  // guarantees the range starts at or below the address.
  always_comb begin
    dec_status = STAT_GRANTED;
    dec_op     = UPD_NONE;
    if (!res_r.found) begin
      dec_status = STAT_NO_RANGE;
    end else if (ovf_r || (res_r.best_limit < req_end_r)) begin
      dec_status = STAT_NOT_CONTAINED;
    end else if (res_r.best_base == addr_r) begin
      dec_op = (res_r.best_limit == req_end_r) ? UPD_DROP : UPD_TRIM_FRONT;
    end else if (res_r.best_limit == req_end_r) begin
      dec_op = UPD_TRIM_BACK;
    end else if (res_r.spare_found) begin
      dec_op = UPD_SPLIT;
    end else begin
      dec_status = STAT_FULL;
    end
  end

  // Next state, handshake and table update
  always_comb begin
    state_nxt     = state_r;
    launch_nxt    = 1'b0;
    out_valid_nxt = out_valid_r;
    upd           = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          launch_nxt = 1'b1;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // hold until the search word leaves the last cell
        if (link[FREE_ENTRIES].go) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        // wait for the output register, then commit
        if (commit) begin
          out_valid_nxt       = 1'b1;
          state_nxt           = ST_IDLE;
          upd.op              = dec_op;
          upd.val_base        = req_end_r;
          upd.val_limit       = addr_r;
          upd.val_split_limit = res_r.best_limit;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // A pool write reloads the whole table with the single pool range.
    if (cfg_load) begin
      upd.op        = UPD_LOAD;
      upd.val_base  = (cfg_index == CFG_POOL_START) ? cfg_data : pool_start_r;
      upd.val_limit = (cfg_index == CFG_POOL_END)   ? cfg_data : pool_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_start_r <= '0;
      pool_end_r   <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == CFG_POOL_START) pool_start_r <= cfg_data;
      if (cfg_index == CFG_POOL_END)   pool_end_r   <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_r    <= in_request_addr;
      req_end_r <= sum[ADDR_W-1:0];
      ovf_r     <= sum[ADDR_W];
    end
    if ((state_r == ST_SCAN) && link[FREE_ENTRIES].go) begin
      res_r           <= link[FREE_ENTRIES];
      res_best_idx_r  <= best_idx[FREE_ENTRIES];
      res_spare_idx_r <= spare_idx[FREE_ENTRIES];
    end
    if (commit) begin
      out_status_r <= dec_status;
      out_start_r  <= (dec_status == STAT_GRANTED) ? addr_r    : '0;
      out_end_r    <= (dec_status == STAT_GRANTED) ? req_end_r : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_start = out_start_r;
  assign out_granted_end   = out_end_r;

endmodule

`default_nettype wire

>>> rtl/far_cell.sv
`default_nettype none

module far_cell
  import far_pkg::*;
#(
  parameter int unsigned ENTRIES = 16,
  parameter int unsigned SLOT    = 0,
  localparam int unsigned IDX_W  = $clog2(ENTRIES)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire scan_t            scan_i,
  input  wire logic [IDX_W-1:0] best_idx_i,
  input  wire logic [IDX_W-1:0] spare_idx_i,
  output      scan_t            scan_o,
  output      logic [IDX_W-1:0] best_idx_o,
  output      logic [IDX_W-1:0] spare_idx_o,
  input  wire upd_t             upd_i,
  input  wire logic [IDX_W-1:0] sel_idx_i,
  input  wire logic [IDX_W-1:0] spr_idx_i
);

  localparam logic [IDX_W-1:0] SLOT_ID = IDX_W'(SLOT);
  localparam bit               IS_HEAD = (SLOT == 0);

  logic              valid_r, valid_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;
  logic [ADDR_W-1:0] limit_r, limit_nxt;
  scan_t             scan_r, scan_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [IDX_W-1:0]  spare_idx_r, spare_idx_nxt;
  logic              take, spare_take, is_sel, is_spr;

  // Take over as best when this range starts at or below the address and
  // strictly above the best so far; ties keep the lower slot.
  always_comb begin
    take = valid_r && (base_r <= scan_i.addr) &&
           (!scan_i.found || (base_r > scan_i.best_base));
    spare_take = !valid_r && !scan_i.spare_found;
    scan_nxt      = scan_i;
    best_idx_nxt  = best_idx_i;
    spare_idx_nxt = spare_idx_i;
    if (take) begin
      scan_nxt.found      = 1'b1;
      scan_nxt.best_base  = base_r;
      scan_nxt.best_limit = limit_r;
      best_idx_nxt        = SLOT_ID;
    end
    if (spare_take) begin
      scan_nxt.spare_found = 1'b1;
      spare_idx_nxt        = SLOT_ID;
    end
  end

  always_comb begin
    is_sel    = (sel_idx_i == SLOT_ID);
    is_spr    = (spr_idx_i == SLOT_ID);
    valid_nxt = valid_r;
    base_nxt  = base_r;
    limit_nxt = limit_r;
    unique case (upd_i.op)
      UPD_LOAD: begin
        valid_nxt = IS_HEAD;
        if (IS_HEAD) begin
          base_nxt  = upd_i.val_base;
          limit_nxt = upd_i.val_limit;
        end
      end
      UPD_DROP: begin
        if (is_sel) valid_nxt = 1'b0;
      end
      UPD_TRIM_FRONT: begin
        if (is_sel) base_nxt = upd_i.val_base;
      end
      UPD_TRIM_BACK: begin
        if (is_sel) limit_nxt = upd_i.val_limit;
      end
      UPD_SPLIT: begin
        if (is_sel) limit_nxt = upd_i.val_limit;
        if (is_spr) begin
          valid_nxt = 1'b1;
          base_nxt  = upd_i.val_base;
          limit_nxt = upd_i.val_split_limit;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= IS_HEAD;
      base_r  <= '0;
      limit_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      base_r  <= base_nxt;
      limit_r <= limit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r.go <= 1'b0;
    end else begin
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    spare_idx_r <= spare_idx_nxt;
  end

  assign scan_o      = scan_r;
  assign best_idx_o  = best_idx_r;
  assign spare_idx_o = spare_idx_r;

endmodule

`default_nettype wire

>>> rtl/far_check.sv
`default_nettype none

module far_check
  import far_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic [ADDR_W-1:0]    in_request_addr,
  input wire logic [ADDR_W-1:0]    in_request_size,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [STATUS_W-1:0]  out_status,
  input wire logic [ADDR_W-1:0]    out_granted_start,
  input wire logic [ADDR_W-1:0]    out_granted_end,
  input wire logic                 cfg_valid,
  input wire logic                 cfg_ready,
  input wire logic [CFG_IDX_W-1:0] cfg_index,
  input wire logic [ADDR_W-1:0]    cfg_data
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_status) &&
      $stable(out_granted_start) && $stable(out_granted_end))
    else $error("result word changed while stalled");

  // Error results carry an empty span.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != STAT_GRANTED) |->
      (out_granted_start == '0) && (out_granted_end == '0))
    else $error("error result with nonzero span");

  // A granted span never wraps.
  a_grant_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STAT_GRANTED) |->
      out_granted_end >= out_granted_start)
    else $error("granted span wraps");

  // One request in flight: ready drops right after an accept.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in flight");

endmodule

bind fixed_address_range_allocator far_check u_far_check (.*);

`default_nettype wire

>>> verif/fixed_address_range_allocator_test.sv
`default_nettype none

module fixed_address_range_allocator_test;
  import far_pkg::*;

  localparam int unsigned FREE_ENTRIES = 16;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  // Indexes that map to no register; writes to them must leave the table alone.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNMAPPED_HI = 2'd3;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] first;
    logic [ADDR_W-1:0] past;
  } grant_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]  a;
    logic [ADDR_W-1:0]  b;
    bit                 typed;
    grant_t             want;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [ADDR_W-1:0]    in_request_addr;
  logic [ADDR_W-1:0]    in_request_size;
  logic                 out_valid;
  logic                 out_ready;
  logic [STATUS_W-1:0]  out_status;
  logic [ADDR_W-1:0]    out_granted_start;
  logic [ADDR_W-1:0]    out_granted_end;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADDR_W-1:0]    cfg_data;

  // Shadow copy of the pool registers and the free-range table.
  logic [ADDR_W-1:0] pool_first;
  logic [ADDR_W-1:0] pool_past;
  logic [ADDR_W-1:0] free_base  [FREE_ENTRIES];
  logic [ADDR_W-1:0] free_limit [FREE_ENTRIES];
  bit                free_used  [FREE_ENTRIES];

  grant_t grants_due[$];
  row_t   script[$];
  int     error_count;
  int     cycle_count;
  bit     quiet_tail;
  bit     hold_arm;

  fixed_address_range_allocator #(.FREE_ENTRIES(FREE_ENTRIES)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_request_addr   (in_request_addr),
    .in_request_size   (in_request_size),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_granted_start (out_granted_start),
    .out_granted_end   (out_granted_end),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Clear the table and load the single pool range, as a register write does.
  function automatic void reload_free_table();
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      free_base[i]  = '0;
      free_limit[i] = '0;
      free_used[i]  = 1'b0;
    end
    free_base[0]  = pool_first;
    free_limit[0] = pool_past;
    free_used[0]  = 1'b1;
  endfunction

  // Work out the grant for one request and commit the table update.
  function automatic grant_t grant_for(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] size);
    grant_t            g;
    logic [ADDR_W-1:0] stop;
    int                sel;
    int                spare;
    stop  = addr + size;
    sel   = -1;
    spare = -1;
    // Greatest start at or below addr; strict compare keeps the lower slot on a tie.
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      if (free_used[i] && free_base[i] <= addr) begin
        if (sel < 0) sel = i;
        else if (free_base[i] > free_base[sel]) sel = i;
      end
    end
    for (int i = FREE_ENTRIES - 1; i >= 0; i--) begin
      if (!free_used[i]) spare = i;
    end
    g.status = STAT_GRANTED;
    if (sel < 0) begin
      g.status = STAT_NO_RANGE;
    end else if (stop < addr || free_limit[sel] < stop) begin
      // a wrapped end address lands here too
      g.status = STAT_NOT_CONTAINED;
    end else if (free_base[sel] == addr) begin
      if (free_limit[sel] == stop) begin
        free_used[sel]  = 1'b0;
        free_base[sel]  = '0;
        free_limit[sel] = '0;
      end else begin
        free_base[sel] = stop;
      end
    end else if (free_limit[sel] == stop) begin
      free_limit[sel] = addr;
    end else if (spare < 0) begin
      g.status = STAT_FULL;
    end else begin
      free_base[spare]  = stop;
      free_limit[spare] = free_limit[sel];
      free_used[spare]  = 1'b1;
      free_limit[sel]   = addr;
    end
    g.first = (g.status == STAT_GRANTED) ? addr : '0;
    g.past  = (g.status == STAT_GRANTED) ? stop : '0;
    return g;
  endfunction

  function automatic void add_row(row_kind_t kind, logic [CFG_IDX_W-1:0] idx,
                                  logic [ADDR_W-1:0] a, logic [ADDR_W-1:0] b, bit typed,
                                  status_t st, logic [ADDR_W-1:0] first,
                                  logic [ADDR_W-1:0] past);
    row_t r;
    r.kind        = kind;
    r.idx         = idx;
    r.a           = a;
    r.b           = b;
    r.typed       = typed;
    r.want.status = st;
    r.want.first  = first;
    r.want.past   = past;
    script.push_back(r);
  endfunction

  task automatic flag_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    $display("ERROR %s: got %h, want %h", what, got, want);
    error_count++;
  endtask

  // Offer one request word; record the expected grant on the accepting edge.
  task automatic offer_request(logic [ADDR_W-1:0] addr, logic [ADDR_W-1:0] size, bit typed,
                               grant_t want);
    grant_t due;
    int     gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_request_addr <= addr;
    in_request_size <= size;
    do @(posedge clk); while (!in_ready);
    due = grant_for(addr, size);
    // typed rows still advance the shadow table, but the typed value is what counts
    grants_due.push_back(typed ? want : due);
  endtask

  // Drop valid, wait for every grant to come back, then let the block settle.
  task automatic wait_for_quiet();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (FREE_ENTRIES + 6) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [ADDR_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_POOL_START: begin
        pool_first = value;
        reload_free_table();
      end
      CFG_POOL_END: begin
        pool_past = value;
        reload_free_table();
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Mostly aim requests at live free ranges (exact fit, trims, splits, overruns),
  // with some wrapping requests and plain noise mixed in.
  task automatic pick_request(output logic [ADDR_W-1:0] addr, output logic [ADDR_W-1:0] size);
    int                live[$];
    int                k;
    int                j;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] span;
    logic [ADDR_W-1:0] off;
    logic [ADDR_W-1:0] room;
    for (int i = 0; i < FREE_ENTRIES; i++) begin
      if (free_used[i] && free_limit[i] > free_base[i]) live.push_back(i);
    end
    k    = $urandom_range(0, 99);
    addr = rand64();
    size = rand64();
    if (k < 80 && live.size() == 0) begin
      // no live free range (empty or inverted pool, or all of it granted): poke at the pool start
      addr = pool_first;
      size = $urandom_range(0, 3);
    end else if (k < 80) begin
      j    = live[$urandom_range(0, live.size() - 1)];
      lo   = free_base[j];
      hi   = free_limit[j];
      span = hi - lo;
      off  = $urandom_range(0, 1) ? rand64() % span : $urandom_range(0, 15) % span;
      case ($urandom_range(0, 6))
        0: begin
          addr = lo;
          size = span;
        end
        1: begin
          addr = lo;
          size = off;
        end
        2: begin
          addr = lo + off;
          size = hi - addr;
        end
        3, 4: begin
          addr = lo + off;
          room = hi - addr;
          size = $urandom_range(0, 1) ? $urandom_range(0, 7) : rand64() % span;
          if (size > room) size = room;
        end
        5: begin
          addr = lo + off;
          size = hi - addr + 1;
        end
        default: begin
          addr = lo - 1 - $urandom_range(0, 7);
          size = $urandom_range(0, 3);
        end
      endcase
    end else if (k < 90) begin
      // end address wraps past the top
      addr = ADDR_MAX - $urandom_range(0, 255);
      size = (ADDR_MAX - addr) + 1 + $urandom_range(0, 3);
    end
  endtask

  // Result side: random ready bursts, one long hold-off on request, and the check.
  initial begin
    grant_t due;
    int     hold_left;
    int     burst_left;
    hold_left  = 0;
    burst_left = 0;
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          flag_mismatch("result word with no grant due", out_granted_start, '0);
        end else begin
          due = grants_due.pop_front();
          if (out_status !== due.status)
            flag_mismatch("status", ADDR_W'(out_status), ADDR_W'(due.status));
          if (out_granted_start !== due.first)
            flag_mismatch("granted_start", out_granted_start, due.first);
          if (out_granted_end !== due.past)
            flag_mismatch("granted_end", out_granted_end, due.past);
        end
      end
      if (hold_arm) begin
        hold_arm  = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        out_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst_left = $urandom_range(1, 3) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  // Request and configuration side.
  initial begin
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] size;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    grant_t            none;
    int                items;
    error_count     = 0;
    quiet_tail      = 1'b0;
    hold_arm        = 1'b0;
    none            = '0;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_request_addr <= '0;
    in_request_size <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    pool_first      = '0;
    pool_past       = '0;
    reload_free_table();

    // Directed table. Pool is empty [0, 0) after reset.
    add_row(ROW_REQ, '0, '0, '0, 1, STAT_GRANTED, '0, '0);   // exact fit on empty range
    add_row(ROW_REQ, '0, '0, '0, 1, STAT_NO_RANGE, '0, '0);
    add_row(ROW_CFG, CFG_IDX_UNMAPPED_LO, ADDR_MAX, '0, 0, STAT_GRANTED, '0, '0);
    add_row(ROW_CFG, CFG_IDX_UNMAPPED_HI, 64'h5555_5555_5555_5555, '0, 0, STAT_GRANTED, '0, '0);
    add_row(ROW_REQ, '0, 64'd5, '0, 1, STAT_NO_RANGE, '0, '0);  // ignored writes kept it empty
    add_row(ROW_CFG, CFG_POOL_END, ADDR_MAX, '0, 0, STAT_GRANTED, '0, '0);
    add_row(ROW_REQ, '0, ADDR_MAX, 64'd1, 1, STAT_NOT_CONTAINED, '0, '0);    // end wraps
    add_row(ROW_REQ, '0, ADDR_MAX - 1, 64'd1, 1, STAT_GRANTED, ADDR_MAX - 1, ADDR_MAX);
    add_row(ROW_REQ, '0, '0, 64'd16, 1, STAT_GRANTED, '0, 64'd16);           // trim front
    add_row(ROW_REQ, '0, 64'd100, 64'd10, 1, STAT_GRANTED, 64'd100, 64'd110); // split
    add_row(ROW_REQ, '0, 64'd50, '0, 0, STAT_GRANTED, '0, '0);          // empty span, interior
    add_row(ROW_REQ, '0, 64'd16, '0, 1, STAT_GRANTED, 64'd16, 64'd16);  // empty span at start
    add_row(ROW_REQ, '0, 64'd40, 64'd20, 1, STAT_NOT_CONTAINED, '0, '0);
    add_row(ROW_REQ, '0, ADDR_MAX, ADDR_MAX, 1, STAT_NOT_CONTAINED, '0, '0);
    // Fill the table with empty-span splits, then ask for one more split.
    for (int n = 111; n <= 123; n++)
      add_row(ROW_REQ, '0, 64'(n), '0, 0, STAT_GRANTED, '0, '0);
    add_row(ROW_REQ, '0, 64'd200, '0, 1, STAT_FULL, '0, '0);
    // Inverted pool never holds a span.
    add_row(ROW_CFG, CFG_POOL_START, 64'd200, '0, 0, STAT_GRANTED, '0, '0);
    add_row(ROW_CFG, CFG_POOL_END, 64'd100, '0, 0, STAT_GRANTED, '0, '0);
    add_row(ROW_REQ, '0, 64'd200, '0, 1, STAT_NOT_CONTAINED, '0, '0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[r]) begin
      if (script[r].kind == ROW_CFG) begin
        wait_for_quiet();
        write_register(script[r].idx, script[r].a);
      end else begin
        offer_request(script[r].a, script[r].b, script[r].typed, script[r].want);
      end
    end

    // Random phases, each on a fresh pool written while the block is idle.
    for (int phase = 0; phase < 7; phase++) begin
      wait_for_quiet();
      lo    = rand64();
      hi    = rand64();
      items = 160;
      case (phase)
        0: begin
          lo = '0;
          hi = ADDR_MAX;
        end
        1: begin
          lo = ADDR_MAX - 4095;
          hi = ADDR_MAX;
        end
        2: hi = lo + $urandom_range(32, 2048);
        3: begin
          items = 150;
          write_register(CFG_IDX_UNMAPPED_LO, rand64());
          write_register(CFG_IDX_UNMAPPED_HI, rand64());
        end
        4: begin
          items = 40;
          hi    = lo;
        end
        5: begin
          items = 190;
          lo    = '0;
          hi    = $urandom_range(16, 256);
        end
        default: begin
          items      = 190;
          hi         = lo + $urandom_range(256, 4096);
          quiet_tail = 1'b1;
        end
      endcase
      if ($urandom_range(0, 1) == 0) begin
        write_register(CFG_POOL_START, lo);
        write_register(CFG_POOL_END, hi);
      end else begin
        write_register(CFG_POOL_END, hi);
        write_register(CFG_POOL_START, lo);
      end
      // Hold off the result side for a long stretch so the input backs up.
      if (phase == 1) hold_arm = 1'b1;
      for (int n = 0; n < items; n++) begin
        pick_request(addr, size);
        offer_request(addr, size, 0, none);
      end
    end

    wait_for_quiet();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
